// ----- rtl/sublist_occurrence_search_top_macros.svh -----
// Assertion macros used by the checker file.
`ifndef SUBLIST_OCCURRENCE_SEARCH_TOP_MACROS_SVH
`define SUBLIST_OCCURRENCE_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SOS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sos_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sos_pkg
// Request and response types, function and status codes of the search block.
// ----------------------------------------------------------------------------
package sos_pkg;

	localparam logic [1:0] FUNC_PATTERN = 2'd0;
	localparam logic [1:0] FUNC_TEXT    = 2'd1;
	localparam logic [1:0] FUNC_REPORT  = 2'd2;

	localparam logic [2:0] STATUS_FOUND     = 3'd0;
	localparam logic [2:0] STATUS_NOT_FOUND = 3'd1;
	localparam logic [2:0] STATUS_EMPTY_PAT = 3'd2;
	localparam logic [2:0] STATUS_EMPTY_TXT = 3'd3;
	localparam logic [2:0] STATUS_OVERFLOW  = 3'd4;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] value;
	} sos_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] first_index;
		logic [15:0] last_index;
	} sos_rsp_t;

	typedef struct packed {
		logic load;
		logic text;
		logic clear;
	} sos_cell_ctl_t;

endpackage

// ----- rtl/sos_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sos_cell
// One pattern position: holds a pattern word and its partial-match bit,
// extends the match handed over by the previous cell on every text word.
// ----------------------------------------------------------------------------
module sos_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sos_pkg::sos_cell_ctl_t ctl,
	input  logic                   active,
	input  logic                   prev_hit,
	input  logic [31:0]            word,
	output logic                   hit_d,
	output logic                   hit_q
);
	import sos_pkg::*;

	logic [31:0] pat_q;

	assign hit_d = active & prev_hit & (pat_q == word);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			pat_q <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q <= 1'b0;
		end else if (ctl.text) begin
			hit_q <= hit_d;
		end
	end

endmodule

// ----- rtl/sublist_occurrence_search_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sublist_occurrence_search_top
// Streamed pattern search over a row of compare cells, one per pattern word.
// ----------------------------------------------------------------------------
//  channel | ports                         | moves
//  in      | in_valid, in_stall, in_data   | pattern word, text word or report
//  out     | out_valid, out_stall, out_data| one response per report request
//
//  One request per cycle is accepted unless a held response stalls a report request.
//  All cells compare a text word at once; the match bit moves one cell a word.
//  A response appears in the cycle after its report request.
//  A held response stalls only a further report request.
//  Reset clears the length, counters and match bits; no clearing pass.
// ----------------------------------------------------------------------------
module sublist_occurrence_search_top #(
	parameter int PAT_MAX  = 16,
	parameter int TEXT_MAX = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sos_pkg::sos_req_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output sos_pkg::sos_rsp_t out_data
);
	import sos_pkg::*;

	localparam int LW = $clog2(PAT_MAX + 1);
	localparam int CW = $clog2(TEXT_MAX + 1);
	localparam int SW = (CW > 16) ? CW : 16;

	logic [LW-1:0]      len_q;
	logic               ovf_q;
	logic [CW-1:0]      count_q;
	logic               found_q;
	logic [15:0]        first_q;
	logic [15:0]        last_q;
	logic               out_valid_q;
	sos_rsp_t           out_q;

	logic               acc;
	logic               do_pat;
	logic               do_text;
	logic               do_rep;
	logic               sat;
	logic               hit;
	logic [SW-1:0]      start_w;
	logic [PAT_MAX-1:0] hit_d;
	logic [PAT_MAX-1:0] hit_q;
	logic [PAT_MAX-1:0] top_mask;
	sos_rsp_t           rsp;

	assign in_stall = out_valid_q & out_stall & (in_data.func == FUNC_REPORT);
	assign acc      = in_valid & ~in_stall;
	assign sat      = (count_q == CW'(TEXT_MAX));
	assign do_pat   = acc & (in_data.func == FUNC_PATTERN) & (count_q == '0);
	assign do_text  = acc & (in_data.func == FUNC_TEXT) & ~sat;
	assign do_rep   = acc & (in_data.func == FUNC_REPORT);

	for (genvar j = 0; j < PAT_MAX; j++) begin : g_cell
		sos_cell_ctl_t ctl;
		logic          prev;

		assign ctl.load  = do_pat & (len_q == LW'(j));
		assign ctl.text  = do_text;
		assign ctl.clear = do_rep;
		assign top_mask[j] = (len_q == LW'(j + 1));

		if (j == 0) begin : g_first
			assign prev = 1'b1;
		end else begin : g_next
			assign prev = hit_q[j-1];
		end

		sos_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.active   (len_q > LW'(j)),
			.prev_hit (prev),
			.word     (in_data.value),
			.hit_d    (hit_d[j]),
			.hit_q    (hit_q[j])
		);
	end

	assign hit     = |(hit_d & top_mask);
	assign start_w = SW'(count_q) + SW'(1) - SW'(len_q);

	always_comb begin
		rsp = '0;
		if (ovf_q) begin
			rsp.status = STATUS_OVERFLOW;
		end else if (len_q == '0) begin
			rsp.status = STATUS_EMPTY_PAT;
		end else if (count_q == '0) begin
			rsp.status = STATUS_EMPTY_TXT;
		end else if (found_q) begin
			rsp.status      = STATUS_FOUND;
			rsp.first_index = first_q;
			rsp.last_index  = last_q;
		end else begin
			rsp.status = STATUS_NOT_FOUND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			ovf_q   <= 1'b0;
			count_q <= '0;
			found_q <= 1'b0;
			first_q <= '0;
			last_q  <= '0;
		end else if (do_rep) begin
			len_q   <= '0;
			ovf_q   <= 1'b0;
			count_q <= '0;
			found_q <= 1'b0;
			first_q <= '0;
			last_q  <= '0;
		end else if (do_pat) begin
			if (len_q == LW'(PAT_MAX)) begin
				ovf_q <= 1'b1;
			end else begin
				len_q <= len_q + LW'(1);
			end
		end else if (do_text) begin
			count_q <= count_q + CW'(1);
			if (hit) begin
				if (!found_q) begin
					first_q <= start_w[15:0];
				end
				last_q  <= start_w[15:0];
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_rep) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_rep) begin
			out_q <= rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- rtl/sos_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sos_checker
// Port-level checks of the search block, bound to the top level.
// ----------------------------------------------------------------------------
`include "sublist_occurrence_search_top_macros.svh"

module sos_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input sos_pkg::sos_req_t in_data,
	input logic              out_valid,
	input logic              out_stall,
	input sos_pkg::sos_rsp_t out_data
);
	import sos_pkg::*;

	`SOS_ASSERT_NEXT(a_rsp_after_report, clk, arst_n,
		in_valid && !in_stall && in_data.func == FUNC_REPORT, out_valid,
		"report request gave no response")

	`SOS_ASSERT_IMPLY(a_status_range, clk, arst_n, out_valid,
		out_data.status <= STATUS_OVERFLOW, "response status out of range")

	`SOS_ASSERT_IMPLY(a_idx_zero, clk, arst_n,
		out_valid && out_data.status != STATUS_FOUND,
		out_data.first_index == 16'd0 && out_data.last_index == 16'd0,
		"indices set without a match")

	`SOS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_data), "stalled response changed")

endmodule

bind sublist_occurrence_search_top sos_checker u_sos_checker (.*);
